FILE: hw/rtl/differential_drive_odometry_unit_defines.svh
// assertion macros used by the odometry back stage
// expects clk and rst_n in the scope of each use
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH

// same-cycle implication
`define DDO_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed in the same cycle");

// next-cycle implication
`define DDO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed in the following cycle");

`endif

FILE: hw/rtl/ddo_pkg.sv
// shared types, widths, register indexes and the arctangent table of the odometry unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

    localparam int TICK_BITS  = 16;
    localparam int PROD_W     = TICK_BITS + 32;
    localparam int DIST_W     = PROD_W - 16;
    localparam int SUM_W      = DIST_W + 1;
    localparam int TRIG_W     = 34;
    localparam int ATAN_IDX_W = 5;
    localparam int CFG_IDX_W  = 3;

    localparam logic [31:0] CORDIC_START = 32'h26DD_3B6A;

    localparam logic [CFG_IDX_W-1:0] REG_CM_PER_TICK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURNS_PER_CM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd4;

    localparam logic [31:0] CM_PER_TICK_RST  = 32'd5007200;
    localparam logic [31:0] TURNS_PER_CM_RST = 32'd37975671;

    typedef struct packed {
        logic signed [TICK_BITS-1:0] ticks_right;
        logic signed [TICK_BITS-1:0] ticks_left;
    } ddo_in_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic        [31:0] pose_heading;
    } ddo_out_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] diff;
    } ddo_step_t;

    typedef struct packed {
        logic               done;
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] sin_val;
    } ddo_trig_t;

    typedef struct packed {
        logic        load;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] heading;
    } ddo_load_t;

    function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            5'd24:   val = 32'h0000_0029;
            5'd25:   val = 32'h0000_0014;
            5'd26:   val = 32'h0000_000A;
            5'd27:   val = 32'h0000_0005;
            5'd28:   val = 32'h0000_0003;
            5'd29:   val = 32'h0000_0001;
            5'd30:   val = 32'h0000_0001;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/differential_drive_odometry_unit.sv
// differential-drive odometry: wheel tick deltas in, updated pose out
// holds the configuration registers; depends on ddo_pkg, ddo_fifo, ddo_front, ddo_cordic, ddo_back
//
// usage
//   input queue: drive ticks and raise push; a transaction is taken on a clock edge with
//   push high and full low. full stays high until the front has scaled an item and pushed it on.
//   result queue: while empty is low the oldest pose sits on pose; pulse pop to take it.
//   configuration: cfg_wr_en with cfg_index and cfg_data writes a register at once, no
//   read-back; writing a start register reloads x, y and heading from the start registers.
//   write configuration only while no transaction is in flight.
// flow
//   the back stage takes one item at a time and pops the next only after pushing a result;
//   its pace is set by the one-rotation-per-cycle cordic.
//   a two-entry queue between front and back and a two-entry result queue let either
//   side stall; when the receiver stops popping, the back holds its result and the
//   queues fill before full rises for good.
// reset
//   rst_n clears the pose to zero, restores the scale factors and empties both queues.
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_odometry_unit
    import ddo_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire ddo_in_t              ticks,
    output logic                      empty,
    input  wire logic                 pop,
    output ddo_out_t                  pose,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int QUEUE_DEPTH = 2;

    logic [31:0] cm_per_tick_reg, cm_per_tick_next;
    logic [31:0] turns_per_cm_reg, turns_per_cm_next;
    logic [31:0] start_x_reg, start_x_next;
    logic [31:0] start_y_reg, start_y_next;
    logic [31:0] start_heading_reg, start_heading_next;

    ddo_load_t   load;
    ddo_step_t   front_step;
    ddo_step_t   back_step;
    logic        step_push;
    logic        step_full;
    logic        step_pop;
    logic        step_empty;
    logic        trig_start;
    logic [31:0] trig_angle;
    ddo_trig_t   trig;
    logic        res_push;
    logic        res_full;
    ddo_out_t    res_pose;

    always_comb
    begin
        cm_per_tick_next   = cm_per_tick_reg;
        turns_per_cm_next  = turns_per_cm_reg;
        start_x_next       = start_x_reg;
        start_y_next       = start_y_reg;
        start_heading_next = start_heading_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CM_PER_TICK:   cm_per_tick_next   = cfg_data;
                REG_TURNS_PER_CM:  turns_per_cm_next  = cfg_data;
                REG_START_X:       start_x_next       = cfg_data;
                REG_START_Y:       start_y_next       = cfg_data;
                REG_START_HEADING: start_heading_next = cfg_data;
                default:           cm_per_tick_next   = cm_per_tick_reg;
            endcase
        end
    end

    assign load.load    = cfg_wr_en
                        && (cfg_index inside {REG_START_X, REG_START_Y, REG_START_HEADING});
    assign load.x       = start_x_next;
    assign load.y       = start_y_next;
    assign load.heading = start_heading_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cm_per_tick_reg   <= CM_PER_TICK_RST;
            turns_per_cm_reg  <= TURNS_PER_CM_RST;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
        end
        else
        begin
            cm_per_tick_reg   <= cm_per_tick_next;
            turns_per_cm_reg  <= turns_per_cm_next;
            start_x_reg       <= start_x_next;
            start_y_reg       <= start_y_next;
            start_heading_reg <= start_heading_next;
        end
    end

    ddo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .ticks       (ticks),
        .cm_per_tick (cm_per_tick_reg),
        .step_push   (step_push),
        .step_full   (step_full),
        .step        (front_step)
    );

    ddo_fifo #(
        .WIDTH ($bits(ddo_step_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_step_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step_push),
        .full  (step_full),
        .wdata (front_step),
        .pop   (step_pop),
        .empty (step_empty),
        .rdata (back_step)
    );

    ddo_cordic #(
        .ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (trig_angle),
        .trig  (trig)
    );

    ddo_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (back_step),
        .step_empty   (step_empty),
        .step_pop     (step_pop),
        .turns_per_cm (turns_per_cm_reg),
        .load         (load),
        .trig_start   (trig_start),
        .trig_angle   (trig_angle),
        .trig         (trig),
        .res_push     (res_push),
        .res_full     (res_full),
        .pose         (res_pose)
    );

    ddo_fifo #(
        .WIDTH ($bits(ddo_out_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_pose),
        .pop   (pop),
        .empty (empty),
        .rdata (pose)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/ddo_fifo.sv
// small register queue used between the odometry stages
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ddo_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ddo_front.sv
// front stage: takes tick transactions, scales both wheels to travel, forms sum and difference
// depends on ddo_pkg
`timescale 1ns / 1ps
`default_nettype none

module ddo_front
    import ddo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire ddo_in_t     ticks,
    input  wire logic [31:0] cm_per_tick,
    output logic             step_push,
    input  wire logic        step_full,
    output ddo_step_t        step
);

    localparam int MUL_W = TICK_BITS + 33;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL_R,
        F_MUL_L,
        F_PUSH
    } front_state_t;

    front_state_t                state_reg, state_next;
    logic signed [TICK_BITS-1:0] tr_reg, tr_next;
    logic signed [TICK_BITS-1:0] tl_reg, tl_next;
    logic        [PROD_W-1:0]    pr_reg, pr_next;
    logic        [PROD_W-1:0]    pl_reg, pl_next;

    logic        [TICK_BITS-1:0] tick_sel;
    logic signed [MUL_W-1:0]     tick_ext;
    logic signed [MUL_W-1:0]     scale_ext;
    logic signed [MUL_W-1:0]     mul_full;
    logic        [PROD_W-1:0]    rnd_r;
    logic        [PROD_W-1:0]    rnd_l;
    logic        [DIST_W-1:0]    dr;
    logic        [DIST_W-1:0]    dl;

    assign full      = (state_reg != F_IDLE);
    assign step_push = (state_reg == F_PUSH);

    assign tick_sel  = (state_reg == F_MUL_L) ? tl_reg : tr_reg;
    assign tick_ext  = {{(MUL_W - TICK_BITS){tick_sel[TICK_BITS-1]}}, tick_sel};
    assign scale_ext = {{(MUL_W - 32){1'b0}}, cm_per_tick};
    assign mul_full  = tick_ext * scale_ext;

    // round travel to q16.16
    assign rnd_r = pr_reg + PROD_W'(32768);
    assign rnd_l = pl_reg + PROD_W'(32768);
    assign dr    = rnd_r[PROD_W-1:16];
    assign dl    = rnd_l[PROD_W-1:16];

    assign step.sum  = {dr[DIST_W-1], dr} + {dl[DIST_W-1], dl};
    assign step.diff = {dr[DIST_W-1], dr} - {dl[DIST_W-1], dl};

    always_comb
    begin
        state_next = state_reg;
        tr_next    = tr_reg;
        tl_next    = tl_reg;
        pr_next    = pr_reg;
        pl_next    = pl_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    tr_next    = ticks.ticks_right;
                    tl_next    = ticks.ticks_left;
                    state_next = F_MUL_R;
                end
            end
            F_MUL_R:
            begin
                pr_next    = mul_full[PROD_W-1:0];
                state_next = F_MUL_L;
            end
            F_MUL_L:
            begin
                pl_next    = mul_full[PROD_W-1:0];
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!step_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            tr_reg    <= '0;
            tl_reg    <= '0;
            pr_reg    <= '0;
            pl_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tr_reg    <= tr_next;
            tl_reg    <= tl_next;
            pr_reg    <= pr_next;
            pl_reg    <= pl_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ddo_cordic.sv
// iterative sine and cosine in q1.30 from a 32-bit binary angle, one rotation per cycle
// depends on ddo_pkg (arctangent table, start gain)
`timescale 1ns / 1ps
`default_nettype none

module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int ITERATIONS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] angle,
    output ddo_trig_t        trig
);

    localparam logic [ATAN_IDX_W-1:0] ITER_LAST = ATAN_IDX_W'(ITERATIONS - 1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_MAP
    } cordic_state_t;

    cordic_state_t            state_reg, state_next;
    logic signed [TRIG_W-1:0] x_reg, x_next;
    logic signed [TRIG_W-1:0] y_reg, y_next;
    logic signed [TRIG_W-1:0] z_reg, z_next;
    logic        [1:0]        quad_reg, quad_next;
    logic [ATAN_IDX_W-1:0]    iter_reg, iter_next;
    logic signed [TRIG_W-1:0] cos_reg, cos_next;
    logic signed [TRIG_W-1:0] sin_reg, sin_next;
    logic                     done_reg, done_next;

    logic        [31:0]       biased;
    logic        [1:0]        quad;
    logic        [31:0]       resid;
    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;
    logic signed [TRIG_W-1:0] at;

    assign trig.done    = done_reg;
    assign trig.cos_val = cos_reg;
    assign trig.sin_val = sin_reg;

    // nearest quadrant, residual within an eighth of a turn
    assign biased = angle + 32'h2000_0000;
    assign quad   = biased[31:30];
    assign resid  = angle - {quad, 30'd0};

    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;
    assign at = {{(TRIG_W - 32){1'b0}}, atan_entry(iter_reg)};

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        quad_next  = quad_reg;
        iter_next  = iter_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    x_next     = {{(TRIG_W - 32){1'b0}}, CORDIC_START};
                    y_next     = '0;
                    z_next     = {{(TRIG_W - 32){resid[31]}}, resid};
                    quad_next  = quad;
                    iter_next  = '0;
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                if (!z_reg[TRIG_W-1])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                begin
                    state_next = C_MAP;
                end
            end
            C_MAP:
            begin
                case (quad_reg)
                    2'd0:
                    begin
                        cos_next = x_reg;
                        sin_next = y_reg;
                    end
                    2'd1:
                    begin
                        cos_next = -y_reg;
                        sin_next = x_reg;
                    end
                    2'd2:
                    begin
                        cos_next = -x_reg;
                        sin_next = -y_reg;
                    end
                    default:
                    begin
                        cos_next = y_reg;
                        sin_next = -x_reg;
                    end
                endcase
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            quad_reg  <= '0;
            iter_reg  <= '0;
            cos_reg   <= '0;
            sin_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            quad_reg  <= quad_next;
            iter_reg  <= iter_next;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ddo_back.sv
// back stage: heading change, trig lookup via the cordic, pose update and result push
// depends on ddo_pkg, ddo_cordic outputs and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "differential_drive_odometry_unit_defines.svh"

module ddo_back
    import ddo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ddo_step_t   step,
    input  wire logic        step_empty,
    output logic             step_pop,
    input  wire logic [31:0] turns_per_cm,
    input  wire ddo_load_t   load,
    output logic             trig_start,
    output logic [31:0]      trig_angle,
    input  wire ddo_trig_t   trig,
    output logic             res_push,
    input  wire logic        res_full,
    output ddo_out_t         pose
);

    localparam int TP_W   = SUM_W + 33;
    localparam int HEAD_W = 49;
    localparam int MP_W   = SUM_W + TRIG_W;
    localparam int M_W    = MP_W - 30;
    localparam int STEP_W = M_W + 1;
    localparam int NEW_W  = STEP_W + 1;

    typedef enum logic [3:0] {
        B_IDLE,
        B_TURN,
        B_ANGLE,
        B_CORDIC,
        B_MX,
        B_AX,
        B_MY,
        B_AY,
        B_OUT
    } back_state_t;

    back_state_t             state_reg, state_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SUM_W-1:0] diff_reg, diff_next;
    logic [HEAD_W-1:0]       tprod_reg, tprod_next;
    logic [31:0]             dtheta_reg, dtheta_next;
    logic [MP_W-1:0]         mul_reg, mul_next;
    logic                    neg_reg, neg_next;
    logic signed [31:0]      cur_x_reg, cur_x_next;
    logic signed [31:0]      cur_y_reg, cur_y_next;
    logic [31:0]             cur_heading_reg, cur_heading_next;

    logic signed [TP_W-1:0]   diff_ext;
    logic signed [TP_W-1:0]   turns_ext;
    logic signed [TP_W-1:0]   tprod_full;
    logic [47:0]              dth_rnd;
    logic [HEAD_W-1:0]        half_rnd;
    logic signed [TRIG_W-1:0] c_sel;
    logic [SUM_W-1:0]         sum_mag;
    logic [TRIG_W-1:0]        c_mag;
    logic [MP_W:0]            m_rnd;
    logic [M_W-1:0]           m_val;
    logic [STEP_W-1:0]        step_val;
    logic [31:0]              pos_sel;
    logic [NEW_W-1:0]         new_pos;
    logic [31:0]              pos_sat;

    assign step_pop   = (state_reg == B_IDLE) && !step_empty;
    assign trig_start = (state_reg == B_ANGLE);
    assign res_push   = (state_reg == B_OUT);

    assign pose.pose_x       = cur_x_reg;
    assign pose.pose_y       = cur_y_reg;
    assign pose.pose_heading = cur_heading_reg;

    assign diff_ext   = {{(TP_W - SUM_W){diff_reg[SUM_W-1]}}, diff_reg};
    assign turns_ext  = {{(TP_W - 32){1'b0}}, turns_per_cm};
    assign tprod_full = diff_ext * turns_ext;

    // heading change rounded at 2^16, mid-step half rounded at 2^17
    assign dth_rnd    = tprod_reg[47:0] + 48'h8000;
    assign half_rnd   = tprod_reg + HEAD_W'(32'h1_0000);
    assign trig_angle = cur_heading_reg + half_rnd[HEAD_W-1:17];

    // magnitude product, rounded half away from zero to q16.16
    assign c_sel   = (state_reg == B_MY) ? trig.sin_val : trig.cos_val;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;
    assign c_mag   = c_sel[TRIG_W-1] ? TRIG_W'(-c_sel) : c_sel;

    assign m_rnd    = {1'b0, mul_reg} + (MP_W + 1)'(32'h4000_0000);
    assign m_val    = m_rnd[MP_W:31];
    assign step_val = neg_reg ? -{1'b0, m_val} : {1'b0, m_val};
    assign pos_sel  = (state_reg == B_AY) ? cur_y_reg : cur_x_reg;
    assign new_pos  = {{(NEW_W - 32){pos_sel[31]}}, pos_sel}
                    + {step_val[STEP_W-1], step_val};

    always_comb
    begin
        if (!new_pos[NEW_W-1] && (|new_pos[NEW_W-2:31]))
        begin
            pos_sat = 32'h7FFF_FFFF;
        end
        else if (new_pos[NEW_W-1] && !(&new_pos[NEW_W-2:31]))
        begin
            pos_sat = 32'h8000_0000;
        end
        else
        begin
            pos_sat = new_pos[31:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        sum_next         = sum_reg;
        diff_next        = diff_reg;
        tprod_next       = tprod_reg;
        dtheta_next      = dtheta_reg;
        mul_next         = mul_reg;
        neg_next         = neg_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        cur_heading_next = cur_heading_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!step_empty)
                begin
                    sum_next   = step.sum;
                    diff_next  = step.diff;
                    state_next = B_TURN;
                end
            end
            B_TURN:
            begin
                tprod_next = tprod_full[HEAD_W-1:0];
                state_next = B_ANGLE;
            end
            B_ANGLE:
            begin
                dtheta_next = dth_rnd[47:16];
                state_next  = B_CORDIC;
            end
            B_CORDIC:
            begin
                if (trig.done)
                begin
                    state_next = B_MX;
                end
            end
            B_MX, B_MY:
            begin
                mul_next   = MP_W'(sum_mag) * MP_W'(c_mag);
                neg_next   = sum_reg[SUM_W-1] ^ c_sel[TRIG_W-1];
                state_next = (state_reg == B_MX) ? B_AX : B_AY;
            end
            B_AX:
            begin
                cur_x_next = pos_sat;
                state_next = B_MY;
            end
            B_AY:
            begin
                cur_y_next       = pos_sat;
                cur_heading_next = cur_heading_reg + dtheta_reg;
                state_next       = B_OUT;
            end
            B_OUT:
            begin
                if (!res_full)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        // start register write reloads the pose
        if (load.load)
        begin
            cur_x_next       = load.x;
            cur_y_next       = load.y;
            cur_heading_next = load.heading;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            sum_reg         <= '0;
            diff_reg        <= '0;
            tprod_reg       <= '0;
            dtheta_reg      <= '0;
            mul_reg         <= '0;
            neg_reg         <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            cur_heading_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            sum_reg         <= sum_next;
            diff_reg        <= diff_next;
            tprod_reg       <= tprod_next;
            dtheta_reg      <= dtheta_next;
            mul_reg         <= mul_next;
            neg_reg         <= neg_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            cur_heading_reg <= cur_heading_next;
        end
    end

    `DDO_ASSERT_SAME(a_trig_done_in_wait, trig.done, state_reg == B_CORDIC)
    `DDO_ASSERT_NEXT(a_heading_step, (state_reg == B_AY) && !load.load,
                     cur_heading_reg == $past(cur_heading_reg) + $past(dtheta_reg))
    `DDO_ASSERT_NEXT(a_result_leaves, (state_reg == B_OUT) && !res_full, state_reg == B_IDLE)

endmodule

`default_nettype wire
